// ----- sv/assert_macros.svh -----
// Assertion macros for the checker in pmi_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CHK_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Checked at every edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ----- sv/pmi_pkg.sv -----
// Types, constants and tables for the popcorn map iterator.
`default_nettype none
package pmi_pkg;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int QW = 32;
  localparam int GW = 31;
  localparam int AW = 34;
  localparam int DIV_W = AW + 20;

  localparam logic [29:0] INV2PI = 30'd683565276;
  localparam logic signed [31:0] PIHALF = 32'sd1686629713;
  localparam logic signed [AW-1:0] KINV = 34'sd652032874;
  localparam logic signed [GW-1:0] GAIN_RST = 31'sd52429;
  localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    FUNC_STEP  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_LOAD  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_GAIN    = 2'd0,
    REG_START_X = 2'd1,
    REG_START_Y = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic ld_start;
    logic ld_given;
    logic ld_ang;
    logic pass;
    logic coord;
    logic mul1;
    logic mul2;
    logic cord;
    logic quad;
    logic div_init;
    logic div_step;
    logic tan_fin;
    logic gain;
    logic upd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic cord_done;
    logic div_done;
  } sts_t;

  function automatic logic [AW-1:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return {{(AW-32){1'b0}}, v};
  endfunction
endpackage
`default_nettype wire

// ----- sv/pmi_dpath.sv -----
// Datapath: point and config registers, shared CORDIC, divider, gain multiply.
`default_nettype none
module pmi_dpath #(
  parameter int CORDIC_STEPS = pmi_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pmi_pkg::cmd_t cmd,
  output pmi_pkg::sts_t      sts,
  input  wire logic [63:0]   in_tdata,
  input  wire logic          cfg_xfer,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  output logic [63:0]        out_tdata
);
  localparam int AW = pmi_pkg::AW;
  localparam int QW = pmi_pkg::QW;
  localparam int DW = pmi_pkg::DIV_W;
  localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int DCW = $clog2(DW);

  logic signed [pmi_pkg::GW-1:0] gain_r;
  logic signed [QW-1:0] start_x_r, start_y_r, px_r, py_r, nx_r, ny_r, tan_r;
  logic signed [AW-1:0] ang_r, z_r, cx_r, cy_r, s_r, c_r;
  logic [31:0]          phase_r;
  logic [1:0]           q_r;
  logic [CW-1:0]        cnt_r;
  logic [DCW-1:0]       dcnt_r;
  logic [AW-1:0]        den_r, rem_r;
  logic [DW-1:0]        quo_r;
  logic                 sneg_r, cneg_r, czero_r;
  logic signed [64:0]   gp_r;
  logic [63:0]          out_r;

  logic signed [QW-1:0] v, w, sat_v, tan_v;
  logic signed [AW-1:0] w34, ang_nxt, dx, dy, at, s_mag, c_mag;
  logic signed [64:0]   prod, tsum;
  logic [31:0]          t;
  logic signed [30:0]   r;
  logic signed [62:0]   zp;
  logic [AW:0]          rs;
  logic signed [34:0]   term;
  logic signed [35:0]   diff;

  always_comb begin
    v   = cmd.coord ? py_r : px_r;
    w   = cmd.coord ? px_r : py_r;
    w34 = {{(AW-QW){w[QW-1]}}, w};
    if (cmd.pass) begin
      ang_nxt = w34 + {{(AW-QW){tan_r[QW-1]}}, tan_r};
    end else begin
      ang_nxt = (w34 <<< 1) + w34;
    end
    // phase in turns is bits 51..20 of angle * 1/(2 pi)
    prod = $signed(ang_r) * $signed({1'b0, pmi_pkg::INV2PI});
    t    = phase_r + 32'h2000_0000;
    r    = $signed({1'b0, t[29:0]}) - 31'sd536870912;
    zp   = r * pmi_pkg::PIHALF;
    dx   = cy_r >>> cnt_r;
    dy   = cx_r >>> cnt_r;
    at   = $signed(pmi_pkg::atan_lut(5'(cnt_r)));
    s_mag = s_r[AW-1] ? -s_r : s_r;
    c_mag = c_r[AW-1] ? -c_r : c_r;
    rs   = {rem_r, quo_r[DW-1]};
    if (czero_r) begin
      tan_v = sneg_r ? pmi_pkg::Q_MIN : pmi_pkg::Q_MAX;
    end else if (sneg_r ^ cneg_r) begin
      tan_v = (quo_r > DW'(64'h8000_0000)) ? pmi_pkg::Q_MIN : -$signed(quo_r[QW-1:0]);
    end else begin
      tan_v = (quo_r > DW'(64'h7FFF_FFFF)) ? pmi_pkg::Q_MAX : $signed(quo_r[QW-1:0]);
    end
    tsum = gp_r + 65'sd536870912;
    term = 35'(tsum >>> 30);
    diff = {{4{v[QW-1]}}, v} - {term[34], term};
    if (diff > 36'sh0_7FFF_FFFF) begin
      sat_v = pmi_pkg::Q_MAX;
    end else if (diff < -36'sh0_8000_0000) begin
      sat_v = pmi_pkg::Q_MIN;
    end else begin
      sat_v = diff[QW-1:0];
    end
  end

  assign sts.cord_done = (cnt_r == CW'(CORDIC_STEPS - 1));
  assign sts.div_done  = (dcnt_r == DCW'(DW - 1));
  assign out_tdata     = out_r;

  // config and point registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= pmi_pkg::GAIN_RST;
      start_x_r <= '0;
      start_y_r <= '0;
      px_r      <= '0;
      py_r      <= '0;
    end else begin
      if (cfg_xfer) begin
        unique case (pmi_pkg::reg_idx_t'(cfg_index))
          pmi_pkg::REG_GAIN:    gain_r    <= $signed(cfg_data[pmi_pkg::GW-1:0]);
          pmi_pkg::REG_START_X: start_x_r <= $signed(cfg_data);
          pmi_pkg::REG_START_Y: start_y_r <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (cmd.ld_start) begin
        px_r <= start_x_r;
        py_r <= start_y_r;
      end else if (cmd.ld_given) begin
        px_r <= $signed(in_tdata[31:0]);
        py_r <= $signed(in_tdata[63:32]);
      end else if (cmd.commit) begin
        px_r <= nx_r;
        py_r <= ny_r;
      end
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      dcnt_r <= '0;
    end else begin
      if (cmd.mul2) cnt_r <= '0;
      else if (cmd.cord) cnt_r <= cnt_r + 1'b1;
      if (cmd.div_init) dcnt_r <= '0;
      else if (cmd.div_step) dcnt_r <= dcnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_ang) ang_r <= ang_nxt;
    if (cmd.mul1) phase_r <= prod[51:20];
    if (cmd.mul2) begin
      q_r  <= t[31:30];
      z_r  <= AW'(zp >>> 30);
      cx_r <= pmi_pkg::KINV;
      cy_r <= '0;
    end
    if (cmd.cord) begin
      if (!z_r[AW-1]) begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        z_r  <= z_r - at;
      end else begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        z_r  <= z_r + at;
      end
    end
    if (cmd.quad) begin
      case (q_r)
        2'd0: begin s_r <= cy_r;  c_r <= cx_r;  end
        2'd1: begin s_r <= cx_r;  c_r <= -cy_r; end
        2'd2: begin s_r <= -cy_r; c_r <= -cx_r; end
        default: begin s_r <= -cx_r; c_r <= cy_r; end
      endcase
    end
    if (cmd.div_init) begin
      sneg_r  <= s_r[AW-1];
      cneg_r  <= c_r[AW-1];
      czero_r <= (c_r == '0);
      quo_r   <= {s_mag, 20'd0};
      den_r   <= c_mag;
      rem_r   <= '0;
    end
    if (cmd.div_step) begin
      if (rs >= {1'b0, den_r}) begin
        rem_r <= AW'(rs - {1'b0, den_r});
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= rs[AW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end
    end
    if (cmd.tan_fin) tan_r <= tan_v;
    if (cmd.gain) gp_r <= $signed(gain_r) * s_r;
    if (cmd.upd) begin
      if (cmd.coord) ny_r <= sat_v;
      else nx_r <= sat_v;
    end
    if (cmd.commit) out_r <= {ny_r, nx_r};
  end
endmodule
`default_nettype wire

// ----- sv/pmi_ctrl.sv -----
// Controller: handshakes and sequencing of the datapath micro-steps.
`default_nettype none
module pmi_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [1:0]    in_tuser,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output pmi_pkg::cmd_t      cmd,
  input  wire pmi_pkg::sts_t sts
);
  typedef enum logic [3:0] {
    ST_IDLE, ST_ANG, ST_MUL1, ST_MUL2, ST_CORD, ST_QUAD, ST_DIVI, ST_DIV,
    ST_TANF, ST_GAIN, ST_UPD, ST_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   pass_r, pass_nxt, coord_r, coord_nxt, oval_r, oval_nxt;
  logic   in_xfer, free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = oval_r;
  assign in_xfer    = in_tvalid && in_tready;
  assign free       = !oval_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    coord_nxt = coord_r;
    cmd       = '0;
    cmd.pass  = pass_r;
    cmd.coord = coord_r;
    oval_nxt  = oval_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (pmi_pkg::func_t'(in_tuser))
            pmi_pkg::FUNC_STEP: begin
              state_nxt = ST_ANG;
              pass_nxt  = 1'b0;
              coord_nxt = 1'b0;
            end
            pmi_pkg::FUNC_START: cmd.ld_start = 1'b1;
            pmi_pkg::FUNC_LOAD:  cmd.ld_given = 1'b1;
            default: ;
          endcase
        end
      end
      ST_ANG: begin cmd.ld_ang = 1'b1; state_nxt = ST_MUL1; end
      ST_MUL1: begin cmd.mul1 = 1'b1; state_nxt = ST_MUL2; end
      ST_MUL2: begin cmd.mul2 = 1'b1; state_nxt = ST_CORD; end
      ST_CORD: begin
        cmd.cord = 1'b1;
        if (sts.cord_done) state_nxt = ST_QUAD;
      end
      ST_QUAD: begin
        cmd.quad  = 1'b1;
        state_nxt = pass_r ? ST_GAIN : ST_DIVI;
      end
      ST_DIVI: begin cmd.div_init = 1'b1; state_nxt = ST_DIV; end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_TANF;
      end
      ST_TANF: begin
        cmd.tan_fin = 1'b1;
        pass_nxt    = 1'b1;
        state_nxt   = ST_ANG;
      end
      ST_GAIN: begin cmd.gain = 1'b1; state_nxt = ST_UPD; end
      ST_UPD: begin
        cmd.upd = 1'b1;
        if (coord_r) begin
          state_nxt = ST_COMMIT;
        end else begin
          coord_nxt = 1'b1;
          pass_nxt  = 1'b0;
          state_nxt = ST_ANG;
        end
      end
      ST_COMMIT: begin
        // wait until the output register is free
        if (free) begin
          cmd.commit = 1'b1;
          oval_nxt   = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r  <= 1'b0;
      coord_r <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      coord_r <= coord_nxt;
      oval_r  <= oval_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- sv/popcorn_map_iterator_unit.sv -----
// Popcorn map iterator: one step item gives x,y updated through a shared CORDIC.
// Step: out_tvalid rises after the transfer, once four CORDIC passes of one rotation per cycle
// and two bit-serial divides are done and the output register is free for the commit.
// One item at a time: in_tready stays low until a step is committed; start and load act in idle.
// A finished result waits in the output register while the next item is taken.
// Synchronous active-low reset: point 0, gain 52429, start point 0, no result pending.
`default_nettype none
module popcorn_map_iterator_unit #(
  parameter int CORDIC_STEPS = pmi_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // load_x[31:0], load_y[63:32]
  input  wire logic [1:0]  in_tuser,   // func[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // next_x[31:0], next_y[63:32]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  pmi_pkg::cmd_t cmd;
  pmi_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  pmi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  pmi_dpath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .cfg_xfer  (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata)
  );
endmodule
`default_nettype wire

// ----- sv/pmi_chk.sv -----
// Port-level checker for the popcorn map iterator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module pmi_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic        cfg_ready
);
  `CHK_ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_tvalid, "result pending after reset")
  `CHK_ASSERT(a_no_fast_result, clk, rst_n, $rose(out_tvalid) |-> !$past(in_tvalid && in_tready), "result right after transfer")
  `CHK_ASSERT(a_cfg_ready, clk, rst_n, cfg_ready, "config port not ready")
  `CHK_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
endmodule

bind popcorn_map_iterator_unit pmi_chk u_pmi_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);
`default_nettype wire
